// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the frame builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define SXFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SXFB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/sxfb_pkg.sv =====
`default_nettype none
package sxfb_pkg;

  localparam logic [7:0] SOF_BYTE = 8'hFE;
  localparam logic [7:0] EOF_BYTE = 8'hFF;

  localparam logic FUNC_HDR  = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // byte positions within a frame; payload bytes sit at the length slot
  localparam logic [2:0] POS_SOF  = 3'd0;
  localparam logic [2:0] POS_TYPE = 3'd1;
  localparam logic [2:0] POS_CMD  = 3'd2;
  localparam logic [2:0] POS_LEN  = 3'd3;
  localparam logic [2:0] POS_SUM  = 3'd4;
  localparam logic [2:0] POS_XOR  = 3'd5;
  localparam logic [2:0] POS_EOF  = 3'd6;

  typedef struct packed {
    logic       hdr;
    logic       close;
    logic [7:0] frame_type;
    logic [7:0] command;
    logic [7:0] body;
    logic [7:0] sum;
    logic [7:0] xr;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } push_t;

  typedef struct packed {
    logic            full;
    logic            empty;
    logic [QCW-1:0]  count;
  } qstat_t;

endpackage
`default_nettype wire

// ===== rtl/core/sxfb_if.sv =====
`default_nettype none
interface sxfb_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] frame_type;
  logic [7:0] command;
  logic [7:0] payload_len;
  logic [7:0] data_byte;

  modport source (output valid, func, frame_type, command, payload_len, data_byte,
                  input ready);
  modport sink   (input valid, func, frame_type, command, payload_len, data_byte,
                  output ready);
endinterface

interface sxfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, out_byte, frame_end, input ready);
  modport sink   (input valid, out_byte, frame_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sxfb_front.sv =====
`default_nettype none
module sxfb_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  sxfb_in_if.sink              in_if,
  input  wire sxfb_pkg::qstat_t qstat,
  output sxfb_pkg::push_t      push
);

  logic [7:0] sum_r, sum_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] left_r, left_nxt;
  logic       open_r, open_nxt;
  logic       accept;

  assign in_if.ready = !qstat.full;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    sum_nxt  = sum_r;
    xor_nxt  = xor_r;
    left_nxt = left_r;
    open_nxt = open_r;
    push.push = 1'b0;
    push.job.hdr        = 1'b0;
    push.job.close      = 1'b0;
    push.job.frame_type = in_if.frame_type;
    push.job.command    = in_if.command;
    push.job.body       = in_if.data_byte;
    if (accept) begin
      if (in_if.func == sxfb_pkg::FUNC_HDR) begin
        sum_nxt  = in_if.frame_type + in_if.command + in_if.payload_len;
        xor_nxt  = in_if.frame_type ^ in_if.command ^ in_if.payload_len;
        left_nxt = in_if.payload_len;
        open_nxt = (in_if.payload_len != 8'd0);
        push.push      = 1'b1;
        push.job.hdr   = 1'b1;
        push.job.close = (in_if.payload_len == 8'd0);
        push.job.body  = in_if.payload_len;
      end else if (open_r) begin
        sum_nxt  = sum_r + in_if.data_byte;
        xor_nxt  = xor_r ^ in_if.data_byte;
        left_nxt = left_r - 8'd1;
        open_nxt = (left_r != 8'd1);
        push.push      = 1'b1;
        push.job.close = (left_r == 8'd1);
      end
    end
    push.job.sum = sum_nxt;
    push.job.xr  = xor_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      xor_r  <= '0;
      left_r <= '0;
      open_r <= 1'b0;
    end else begin
      sum_r  <= sum_nxt;
      xor_r  <= xor_nxt;
      left_r <= left_nxt;
      open_r <= open_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sxfb_queue.sv =====
`default_nettype none
module sxfb_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sxfb_pkg::push_t  push,
  input  wire logic             pop,
  output sxfb_pkg::job_t        head,
  output sxfb_pkg::qstat_t      qstat
);

  sxfb_pkg::job_t                mem_r [sxfb_pkg::QDEPTH];
  logic [sxfb_pkg::QAW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [sxfb_pkg::QCW-1:0]      count_r, count_nxt;
  logic                          do_push, do_pop;

  assign qstat.count = count_r;
  assign qstat.full  = (count_r == sxfb_pkg::QCW'(sxfb_pkg::QDEPTH));
  assign qstat.empty = (count_r == '0);
  assign head        = mem_r[rd_ptr_r];

  assign do_push = push.push && !qstat.full;
  assign do_pop  = pop && !qstat.empty;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + sxfb_pkg::QCW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - sxfb_pkg::QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + sxfb_pkg::QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + sxfb_pkg::QAW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sxfb_back.sv =====
`default_nettype none
module sxfb_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sxfb_pkg::job_t   head,
  input  wire sxfb_pkg::qstat_t qstat,
  output logic                  pop,
  sxfb_out_if.source            out_if
);

  logic       out_valid_r;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_end_r;
  logic [2:0] step_r;
  logic [2:0] pos;
  logic [2:0] last_pos;
  logic       load;

  assign out_if.valid     = out_valid_r;
  assign out_if.out_byte  = out_byte_r;
  assign out_if.frame_end = out_end_r;

  assign load     = (!out_valid_r || out_if.ready) && !qstat.empty;
  assign pos      = step_r + (head.hdr ? 3'd0 : sxfb_pkg::POS_LEN);
  assign last_pos = head.close ? sxfb_pkg::POS_EOF : sxfb_pkg::POS_LEN;
  assign pop      = load && (pos == last_pos);

  always_comb begin
    case (pos)
      sxfb_pkg::POS_SOF:  out_byte_nxt = sxfb_pkg::SOF_BYTE;
      sxfb_pkg::POS_TYPE: out_byte_nxt = head.frame_type;
      sxfb_pkg::POS_CMD:  out_byte_nxt = head.command;
      sxfb_pkg::POS_LEN:  out_byte_nxt = head.body;
      sxfb_pkg::POS_SUM:  out_byte_nxt = head.sum;
      sxfb_pkg::POS_XOR:  out_byte_nxt = head.xr;
      default:            out_byte_nxt = sxfb_pkg::EOF_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= out_byte_nxt;
      out_end_r  <= (pos == sxfb_pkg::POS_EOF);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        step_r <= '0;
      end else if (load) begin
        step_r <= step_r + 3'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sum_xor_frame_builder_core.sv =====
// Frame builder: turns header and payload transactions into a byte stream
// 0xFE, type, command, length, payload..., sum, xor, 0xFF.
// in_if  : valid/ready; func 0 is a header (type, command, length),
//          func 1 a payload byte. Payload outside a frame is dropped.
// out_if : valid/ready; one frame byte per transaction, frame_end on 0xFF.
// The first output byte passes through the queue and then the output register.
// Throughput: one input transaction per cycle while the queue is not full.
// A payload transaction yields one byte (four when it closes the frame);
// a header yields four (seven with zero length). The output port, one
// byte per cycle while out_if.ready is high, sets the sustained rate.
// Checksums are computed at acceptance and travel with each entry of a
// four-entry queue between the input and output sides.
// Output stall: the output register holds; the queue fills, then in_if.ready
// drops until an entry leaves the queue. No input is lost to a stall.
// Reset (synchronous, rst_n low): queue empty, no frame open, sums cleared,
// out_if.valid low.
`default_nettype none
`include "assert_macros.svh"
module sum_xor_frame_builder_core (
  input  wire logic clk,
  input  wire logic rst_n,
  sxfb_in_if.sink   in_if,
  sxfb_out_if.source out_if
);

  sxfb_pkg::push_t  push;
  sxfb_pkg::job_t   head;
  sxfb_pkg::qstat_t qstat;
  logic             pop;

  sxfb_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .qstat (qstat),
    .push  (push)
  );

  sxfb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  sxfb_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .out_if (out_if)
  );

  `SXFB_ASSERT(a_count_bound, (qstat.count <= sxfb_pkg::QCW'(sxfb_pkg::QDEPTH)), "queue overflow")
  `SXFB_ASSERT(a_pop_nonempty, (pop |-> !qstat.empty), "pop from empty queue")
  `SXFB_ASSERT(a_end_byte, (out_if.valid && out_if.frame_end |-> out_if.out_byte == sxfb_pkg::EOF_BYTE), "frame end without 0xFF")
  `SXFB_ASSERT_ALWAYS(a_reset_idle, ($past(!rst_n) && rst_n |-> !out_if.valid), "output valid after reset")

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    bit       func;
    bit [7:0] frame_type;
    bit [7:0] command;
    bit [7:0] payload_len;
    bit [7:0] data_byte;
  } in_txn_t;

  typedef struct {
    bit [7:0] value;
    bit       last;
  } frame_byte_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_TRICKLE} rx_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sxfb_in_if  in_ch ();
  sxfb_out_if out_ch ();

  sum_xor_frame_builder_core u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  in_txn_t     pending_txns[$];
  frame_byte_t due_bytes[$];
  int          err_count = 0;

  // predicted frame state
  bit [7:0] chk_sum = '0;
  bit [7:0] chk_xor = '0;
  bit [7:0] bytes_left = '0;
  bit       frame_open = 1'b0;

  // generator view of the frame state, used to classify stray payloads
  bit       gen_open = 1'b0;
  bit [7:0] gen_left = '0;
  int       queued_items = 0;

  function automatic void expect_byte(bit [7:0] v, bit l);
    frame_byte_t fb;
    fb.value = v;
    fb.last  = l;
    due_bytes.push_back(fb);
  endfunction

  function automatic void fold_byte(bit [7:0] b);
    chk_sum = chk_sum + b;
    chk_xor = chk_xor ^ b;
  endfunction

  function automatic void close_frame();
    expect_byte(chk_sum, 1'b0);
    expect_byte(chk_xor, 1'b0);
    expect_byte(sxfb_pkg::EOF_BYTE, 1'b1);
    frame_open = 1'b0;
    bytes_left = '0;
  endfunction

  function automatic void build_frame_bytes(in_txn_t t);
    if (t.func == sxfb_pkg::FUNC_HDR) begin
      chk_sum = '0;
      chk_xor = '0;
      expect_byte(sxfb_pkg::SOF_BYTE, 1'b0);
      expect_byte(t.frame_type, 1'b0);
      expect_byte(t.command, 1'b0);
      expect_byte(t.payload_len, 1'b0);
      fold_byte(t.frame_type);
      fold_byte(t.command);
      fold_byte(t.payload_len);
      bytes_left = t.payload_len;
      frame_open = 1'b1;
      if (t.payload_len == 8'd0) close_frame();
    end else if (frame_open) begin
      expect_byte(t.data_byte, 1'b0);
      fold_byte(t.data_byte);
      bytes_left = bytes_left - 8'd1;
      if (bytes_left == 8'd0) close_frame();
    end
  endfunction

  function automatic void add_header(bit [7:0] ft, bit [7:0] cmd, bit [7:0] len);
    in_txn_t t;
    t.func        = sxfb_pkg::FUNC_HDR;
    t.frame_type  = ft;
    t.command     = cmd;
    t.payload_len = len;
    t.data_byte   = 8'($urandom_range(0, 255));
    pending_txns.push_back(t);
    gen_open = (len != 8'd0);
    gen_left = len;
    queued_items++;
  endfunction

  function automatic void add_payload(bit [7:0] d);
    in_txn_t t;
    t.func        = sxfb_pkg::FUNC_DATA;
    t.frame_type  = 8'($urandom_range(0, 255));
    t.command     = 8'($urandom_range(0, 255));
    t.payload_len = 8'($urandom_range(0, 255));
    t.data_byte   = d;
    pending_txns.push_back(t);
    if (gen_open) begin
      queued_items++;
      gen_left = gen_left - 8'd1;
      if (gen_left == 8'd0) gen_open = 1'b0;
    end
  endfunction

  function automatic void add_frame(bit [7:0] len, int n_payload);
    add_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len);
    for (int i = 0; i < n_payload; i++) add_payload(8'($urandom_range(0, 255)));
  endfunction

  // driver: bursts of transactions separated by random gaps
  in_txn_t cur_txn;
  int      burst_left = 0;
  int      gap_left = 0;

  always @(posedge clk) begin
    bit drive;
    drive = 1'b0;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) build_frame_bytes(cur_txn);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_txns.size() > 0) begin
          cur_txn = pending_txns.pop_front();
          drive = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 23);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        in_ch.valid <= drive;
        if (drive) begin
          in_ch.func        <= cur_txn.func;
          in_ch.frame_type  <= cur_txn.frame_type;
          in_ch.command     <= cur_txn.command;
          in_ch.payload_len <= cur_txn.payload_len;
          in_ch.data_byte   <= cur_txn.data_byte;
        end
      end
    end
  end

  // monitor and output back-pressure
  rx_mode_e rx_mode = RX_OPEN;
  int       mode_cycles = 0;

  always @(posedge clk) begin
    frame_byte_t want;
    bit          rdy;
    rdy = 1'b0;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_bytes.size() == 0) begin
          err_count++;
          $display("%0t: unexpected byte: expected none, actual %02h frame_end %b",
                   $time, out_ch.out_byte, out_ch.frame_end);
        end else begin
          want = due_bytes.pop_front();
          if (out_ch.out_byte !== want.value) begin
            err_count++;
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.value, out_ch.out_byte);
          end
          if (out_ch.frame_end !== want.last) begin
            err_count++;
            $display("%0t: frame_end mismatch: expected %b, actual %b",
                     $time, want.last, out_ch.frame_end);
          end
        end
      end
      if (mode_cycles == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        mode_cycles = $urandom_range(20, 120);
      end else begin
        mode_cycles--;
      end
      case (rx_mode)
        RX_OPEN:   rdy = 1'b1;
        RX_COIN:   rdy = 1'($urandom_range(0, 1));
        RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
        default:   rdy = ((mode_cycles % 12) < 2);
      endcase
      out_ch.ready <= rdy;
    end
  end

  initial begin
    int r;
    int len;
    int n;
    in_ch.valid       = 1'b0;
    in_ch.func        = sxfb_pkg::FUNC_HDR;
    in_ch.frame_type  = '0;
    in_ch.command     = '0;
    in_ch.payload_len = '0;
    in_ch.data_byte   = '0;
    out_ch.ready      = 1'b0;

    // directed: strays, empty frames, field extremes, restarts
    add_payload(8'hFF);
    add_payload(8'h00);
    add_header(8'hFF, 8'hFF, 8'h00);
    add_header(8'h00, 8'h00, 8'h00);
    add_header(8'hA5, 8'h5A, 8'h03);
    add_payload(8'h00);
    add_payload(8'hFF);
    add_payload(8'h81);
    add_payload(8'h3C);
    add_header(8'h12, 8'h34, 8'hFF);
    add_payload(8'h77);
    add_payload(8'h88);
    add_header(8'hFE, 8'hFF, 8'h01);
    add_payload(8'hFE);
    add_header(8'h80, 8'h01, 8'h02);
    add_payload(8'h01);
    add_header(8'h7F, 8'h80, 8'h00);
    add_header(8'hC3, 8'h3C, 8'h01);
    add_payload(8'hFF);

    // one long frame, then mostly short well-formed frames
    len = $urandom_range(128, 255);
    add_frame(8'(len), len);
    while (queued_items < 410) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
        add_frame(8'(len), len);
      end else if (r < 85) begin
        len = $urandom_range(1, 255);
        n = $urandom_range(0, (len - 1 < 6) ? len - 1 : 6);
        add_frame(8'(len), n);
      end else if (!gen_open) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) add_payload(8'($urandom_range(0, 255)));
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_txns.size() > 0 || in_ch.valid) @(posedge clk);
    while (due_bytes.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
